[src/bdch_pkg.sv]
`timescale 1ns / 1ps

package bdch_pkg;

   // width of the wrapping tick arithmetic
   localparam int TIME_BITS = 32;
   localparam int TICK_BITS = 32;
   localparam int CFG_BITS  = 16;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [CFG_BITS-1:0]  cfg_word_type;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD_TICKS     = 2'd1;

   localparam cfg_word_type DEBOUNCE_TICKS_RESET = 16'd30;
   localparam cfg_word_type HOLD_TICKS_RESET     = 16'd500;

   typedef struct packed {
      cfg_word_type debounce_ticks;
      cfg_word_type hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic [TICK_BITS-1:0] now_tick;
      logic                 raw_level;
      logic                 take_click;
      logic                 take_hold;
   } item_type;

   typedef struct packed {
      logic click;
      logic held;
      logic stable_level;
   } result_type;

endpackage

[src/bdch_csr.sv]
`timescale 1ns / 1ps

module bdch_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [bdch_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bdch_pkg::CFG_BITS-1:0]        csr_wdata,
   output bdch_pkg::cfg_type                    cfg
);

   bdch_pkg::cfg_type cfg_ff;
   bdch_pkg::cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            bdch_pkg::CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_wdata;
            bdch_pkg::CSR_HOLD_TICKS:     cfg_in.hold_ticks     = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= bdch_pkg::DEBOUNCE_TICKS_RESET;
         cfg_ff.hold_ticks     <= bdch_pkg::HOLD_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/bdch_core.sv]
`timescale 1ns / 1ps

module bdch_core (
   input  logic                    clock,
   input  logic                    reset,
   input  bdch_pkg::cfg_type       cfg,
   input  logic                    fire,
   input  bdch_pkg::item_type      item,
   output bdch_pkg::result_type    result
);

   logic                level_ff, level_in;
   logic                prev_ff, prev_in;
   bdch_pkg::time_type  change_ff, change_in;
   bdch_pkg::time_type  press_ff, press_in;
   logic                click_ff, click_in;
   logic                hold_ff, hold_in;

   bdch_pkg::time_type  now;
   bdch_pkg::time_type  deb_time;
   bdch_pkg::time_type  hold_time;
   bdch_pkg::time_type  since_change;
   bdch_pkg::time_type  since_press;
   bdch_pkg::time_type  since_press_new;
   logic                raw_changed;
   logic                accept;
   logic                new_press;
   logic                click_n;
   logic                hold_n;

   assign now       = bdch_pkg::time_type'(item.now_tick);
   assign deb_time  = bdch_pkg::time_type'(cfg.debounce_ticks);
   assign hold_time = bdch_pkg::time_type'(cfg.hold_ticks);

   // raw edge restarts the debounce timer
   assign raw_changed  = item.raw_level != prev_ff;
   assign change_in    = raw_changed ? now : change_ff;
   assign since_change = raw_changed ? '0 : now - change_ff;

   // debounced level update
   assign accept    = (since_change >= deb_time) && (level_ff != item.raw_level);
   assign new_press = accept && !item.raw_level;
   assign level_in  = accept ? item.raw_level : level_ff;
   assign press_in  = new_press ? now : press_ff;

   // press length, measured from the old or the fresh press start
   assign since_press     = now - press_ff;
   assign since_press_new = new_press ? '0 : since_press;

   // flags as reported for this transfer
   assign click_n = click_ff
                  | (accept && item.raw_level && (since_press < hold_time));
   assign hold_n  = (hold_ff && !new_press)
                  | (!level_in && (since_press_new >= hold_time));

   // flags left behind after optional take
   assign click_in = click_n && !item.take_click;
   assign hold_in  = hold_n && !item.take_hold;
   assign prev_in  = item.raw_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= 1'b1;
         prev_ff   <= 1'b1;
         change_ff <= '0;
         press_ff  <= '0;
         click_ff  <= 1'b0;
         hold_ff   <= 1'b0;
      end else if (fire) begin
         level_ff  <= level_in;
         prev_ff   <= prev_in;
         change_ff <= change_in;
         press_ff  <= press_in;
         click_ff  <= click_in;
         hold_ff   <= hold_in;
      end
   end

   assign result.click        = click_n;
   assign result.held         = hold_n;
   assign result.stable_level = level_in;

   // state moves only on a transfer into the result stage
   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable({level_ff, prev_ff, click_ff, hold_ff}))
      else $error("core state changed without a transfer");

   // a take always leaves the flag clear
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && item.take_click) |=> !click_ff)
      else $error("click flag survived a take");

   // the click flag is sticky until taken
   a_click_sticky: assert property (@(posedge clock) disable iff (reset)
      (fire && click_ff && !item.take_click) |=> click_ff)
      else $error("click flag lost without a take");

endmodule

[src/button_debounce_click_hold.sv]
`timescale 1ns / 1ps
// flow: a req transfer fills the input register; the item then moves into the
// result register, which holds the state update, and rsp_valid rises with it.
// throughput: one item per cycle unless rsp_stall holds the result stage;
// the debounce state is updated in one pass when the input register moves
// into the result register.
// reset (synchronous): both stages empty, level released, flags clear,
// debounce_ticks 30 and hold_ticks 500.

module button_debounce_click_hold (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bdch_pkg::TICK_BITS-1:0]       req_now_tick,
   input  logic                                 req_raw_level,
   input  logic                                 req_take_click,
   input  logic                                 req_take_hold,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_click,
   output logic                                 rsp_held,
   output logic                                 rsp_stable_level,
   input  logic                                 csr_write_en,
   input  logic [bdch_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bdch_pkg::CFG_BITS-1:0]        csr_wdata
);

   bdch_pkg::cfg_type     cfg;
   bdch_pkg::item_type    in_item_ff;
   logic                  in_valid_ff;
   bdch_pkg::result_type  core_result;
   bdch_pkg::result_type  rsp_ff;
   logic                  rsp_valid_ff;
   logic                  advance;
   logic                  fire;

   bdch_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // stage handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff.now_tick   <= req_now_tick;
         in_item_ff.raw_level  <= req_raw_level;
         in_item_ff.take_click <= req_take_click;
         in_item_ff.take_hold  <= req_take_hold;
      end
   end

   bdch_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_item_ff),
      .result (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_click        = rsp_ff.click;
   assign rsp_held         = rsp_ff.held;
   assign rsp_stable_level = rsp_ff.stable_level;

   // a full input stage that cannot move blocks new transfers
   a_block_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input accepted while both stages full");

   // every item in the input stage reaches the result stage on advance
   a_move_on_advance: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("item lost between stages");

   // a stalled result stage keeps its item
   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("result dropped under stall");

endmodule
